>>> sv/ptl_pkg.sv
// ptl_pkg: item types, command and register codes and measurement constants
// for the proportional text layout core; no dependencies
package ptl_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_CHAR  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_LINE_HEIGHT   = 2'd0,
    REG_GLYPH_SPACING = 2'd1,
    REG_SPACE_ADVANCE = 2'd2
  } reg_index_t;

  localparam int unsigned CFG_BITS   = 12;
  localparam int unsigned MEAS_BITS  = 16;
  localparam int unsigned FIELD_BITS = 16;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [MEAS_BITS-1:0] MEAS_MAX = '1;

  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         char_code;
    logic [11:0]        advance_value;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic               end_of_text;
  } in_item_t;

  typedef struct packed {
    logic               draw_quad;
    logic signed [15:0] quad_x;
    logic signed [15:0] quad_y;
    logic [7:0]         glyph_index;
    logic [11:0]        quad_width;
    logic               final_char;
    logic [15:0]        text_width;
    logic [15:0]        text_height;
  } out_item_t;

endpackage

>>> sv/proportional_text_layout_core.sv
// proportional_text_layout_core: one item per cycle while the output does not stall; from input
// accept an item passes the glyph table read register, then layout into the result register.
// A result waits in the output register while the next item is accepted.
// Load, start and unused commands give no result. Synchronous active-high reset clears
// the pen, measurement, registers and the glyph table valid bits (entries read as zero).
module proportional_text_layout_core
  import ptl_pkg::*;
#(
  parameter int GLYPH_COUNT  = 256,
  parameter int COORD_BITS   = 16,
  parameter int ADVANCE_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data
);

  localparam int ADDR_BITS = $clog2(GLYPH_COUNT);
  localparam int SUM_BITS  = MEAS_BITS + 2;

  logic [CFG_BITS-1:0] line_height, glyph_spacing, space_advance;

  logic [ADVANCE_BITS-1:0] advance_table [GLYPH_COUNT];
  logic [GLYPH_COUNT-1:0]  entry_valid;
  logic [ADVANCE_BITS-1:0] rd_data;
  logic                    rd_valid;

  logic     s1_valid;
  in_item_t s1_item;

  logic [COORD_BITS-1:0] pen_col, pen_row, line_start_col;
  logic [MEAS_BITS-1:0]  line_extent, widest_line, height_total;
  logic                  string_started;

  logic [COORD_BITS-1:0] pen_col_next, pen_row_next, line_start_col_next;
  logic [MEAS_BITS-1:0]  line_extent_next, widest_line_next, height_total_next;
  logic                  string_started_next;
  out_item_t             result;

  logic in_accept, out_free, s1_fire, code_in_table;
  logic [ADDR_BITS-1:0] in_addr;

  function automatic logic [MEAS_BITS-1:0] sat_sum(logic [SUM_BITS-1:0] s);
    return (s > SUM_BITS'(MEAS_MAX)) ? MEAS_MAX : MEAS_BITS'(s);
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_height   <= '0;
      glyph_spacing <= '0;
      space_advance <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LINE_HEIGHT:   line_height   <= cfg_data;
        REG_GLYPH_SPACING: glyph_spacing <= cfg_data;
        REG_SPACE_ADVANCE: space_advance <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: the result register frees the first stage
  assign out_free  = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  assign code_in_table = {1'b0, in_data.char_code} < 9'(GLYPH_COUNT);
  assign in_addr       = ADDR_BITS'(in_data.char_code);

  // glyph table: written by loads at accept, read for every accepted item
  always_ff @(posedge clk) begin
    if (in_accept && in_data.command == CMD_LOAD && code_in_table)
      advance_table[in_addr] <= ADVANCE_BITS'(in_data.advance_value);
    if (in_accept)
      rd_data <= advance_table[in_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (in_accept && in_data.command == CMD_LOAD && code_in_table)
        entry_valid[in_addr] <= 1'b1;
      if (in_accept)
        rd_valid <= entry_valid[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept)
      s1_item <= in_data;
  end

  // layout of one item against the pen and measurement state
  always_comb begin
    logic [ADVANCE_BITS-1:0] w;
    logic [MEAS_BITS-1:0]    le0, wl0, ht0, tw;
    logic                    s1_in_table;

    w           = rd_valid ? rd_data : '0;
    s1_in_table = {1'b0, s1_item.char_code} < 9'(GLYPH_COUNT);

    pen_col_next        = pen_col;
    pen_row_next        = pen_row;
    line_start_col_next = line_start_col;
    line_extent_next    = line_extent;
    widest_line_next    = widest_line;
    height_total_next   = height_total;
    string_started_next = string_started;
    result              = '0;
    tw                  = '0;

    le0 = string_started ? line_extent  : '0;
    wl0 = string_started ? widest_line  : '0;
    ht0 = string_started ? height_total : MEAS_BITS'(line_height);

    case (s1_item.command)
      CMD_START: begin
        pen_col_next        = COORD_BITS'(s1_item.origin_x);
        pen_row_next        = COORD_BITS'(s1_item.origin_y);
        line_start_col_next = COORD_BITS'(s1_item.origin_x);
        line_extent_next    = '0;
        widest_line_next    = '0;
        height_total_next   = '0;
        string_started_next = 1'b0;
      end
      CMD_CHAR: begin
        line_extent_next  = le0;
        widest_line_next  = wl0;
        height_total_next = ht0;
        if (s1_item.char_code == CHAR_NEWLINE) begin
          widest_line_next  = (le0 > wl0) ? le0 : wl0;
          line_extent_next  = '0;
          height_total_next = sat_sum(SUM_BITS'(ht0) + SUM_BITS'(line_height));
          pen_col_next      = line_start_col;
          pen_row_next      = pen_row + COORD_BITS'(line_height);
        end else if (s1_item.char_code == CHAR_SPACE) begin
          pen_col_next     = pen_col + COORD_BITS'(space_advance);
          line_extent_next = sat_sum(SUM_BITS'(le0) + SUM_BITS'(space_advance)
                                     + SUM_BITS'(glyph_spacing));
        end else if (s1_in_table) begin
          result.draw_quad   = 1'b1;
          result.quad_x      = FIELD_BITS'(pen_col);
          result.quad_y      = FIELD_BITS'(pen_row);
          result.glyph_index = s1_item.char_code;
          result.quad_width  = 12'(w);
          pen_col_next       = pen_col + COORD_BITS'(w) + COORD_BITS'(glyph_spacing);
          line_extent_next   = sat_sum(SUM_BITS'(le0) + SUM_BITS'(w)
                                       + SUM_BITS'(glyph_spacing));
        end
        tw = (line_extent_next > widest_line_next) ? line_extent_next : widest_line_next;
        result.final_char   = s1_item.end_of_text;
        result.text_width   = tw;
        result.text_height  = height_total_next;
        string_started_next = !s1_item.end_of_text;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_col        <= '0;
      pen_row        <= '0;
      line_start_col <= '0;
      line_extent    <= '0;
      widest_line    <= '0;
      height_total   <= '0;
      string_started <= 1'b0;
    end else if (s1_fire) begin
      pen_col        <= pen_col_next;
      pen_row        <= pen_row_next;
      line_start_col <= line_start_col_next;
      line_extent    <= line_extent_next;
      widest_line    <= widest_line_next;
      height_total   <= height_total_next;
      string_started <= string_started_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_fire && s1_item.command == CMD_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free)
      out_data <= result;
  end

endmodule

>>> sv/ptl_checker.sv
// ptl_checker: port-level assertions for proportional_text_layout_core, with its bind
// depends on ptl_pkg
module ptl_checker
  import ptl_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // no quad means no placement fields
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.draw_quad |->
      out_data.quad_x == 16'sd0 && out_data.quad_y == 16'sd0 &&
      out_data.glyph_index == 8'd0 && out_data.quad_width == 12'd0)
    else $error("quad fields set without a placed glyph");

  // newline and space never place a glyph
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.draw_quad |->
      out_data.glyph_index != CHAR_NEWLINE && out_data.glyph_index != CHAR_SPACE)
    else $error("glyph placed for newline or space");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

endmodule

bind proportional_text_layout_core ptl_checker u_ptl_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
